// ===== sv/abs_pkg.sv =====
// ----------------------------------------------------------------------------
// abs_pkg
// Shared types, codes and constants of the alternating-bit sender.
// ----------------------------------------------------------------------------
package abs_pkg;

  localparam int unsigned MSG_BYTES       = 20;
  localparam int unsigned QUEUE_DEPTH_DEF = 128;
  localparam int unsigned CMD_DEPTH       = 2;
  localparam int unsigned HALF_BYTES      = MSG_BYTES / 2;

  // Checksum biases applied to the sequence and ack fields
  localparam int unsigned SEQ_BIAS = 10;
  localparam int unsigned ACK_BIAS = 15;

  // Byte weight (i+2)*2
  function automatic int unsigned msg_weight(input int unsigned idx);
    return (idx + 2) * 2;
  endfunction

  localparam int unsigned W_FIRST = msg_weight(0);
  localparam int unsigned W_LAST  = msg_weight(MSG_BYTES - 1);
  // Constant part of a sent packet's checksum (ack field is zero)
  localparam int unsigned SEND_BIAS = SEQ_BIAS * W_FIRST + ACK_BIAS * W_LAST;

  // Payload sum stays below 128 * sum of weights, well inside 18 signed bits
  localparam int unsigned BASE_W = 18;

  typedef enum logic [1:0] {
    MODE_MSG   = 2'd0,
    MODE_ACK   = 2'd1,
    MODE_TIMER = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    TMR_NONE    = 2'd0,
    TMR_START   = 2'd1,
    TMR_STOP    = 2'd2,
    TMR_RESTART = 2'd3
  } tmr_e;

  typedef enum logic [1:0] {
    CMD_MSG,
    CMD_ACK,
    CMD_TIMER,
    CMD_NOP
  } cmd_e;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [63:0]        data_low;
    logic [63:0]        data_mid;
    logic [31:0]        data_high;
    logic signed [31:0] pkt_seq;
    logic signed [31:0] pkt_ack;
    logic signed [31:0] pkt_check;
  } in_beat_t;

  typedef struct packed {
    logic               send_valid;
    logic               send_seq;
    logic signed [31:0] send_check;
    logic [63:0]        send_low;
    logic [63:0]        send_mid;
    logic [31:0]        send_high;
    logic [1:0]         timer_cmd;
    logic               dropped;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] high;
    logic [63:0] mid;
    logic [63:0] low;
  } msg_t;

  // Stored message with its precomputed payload sum
  typedef struct packed {
    msg_t                      msg;
    logic signed [BASE_W-1:0]  base;
  } q_entry_t;

  typedef struct packed {
    cmd_e     kind;
    logic     ack_ok;   // checksum matches and ack field is 0 or 1
    logic     ack_bit;
    q_entry_t ent;
  } cmd_t;

endpackage

// ===== sv/abs_ram.sv =====
// ----------------------------------------------------------------------------
// abs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module abs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/abs_front.sv =====
// ----------------------------------------------------------------------------
// abs_front
// Accept event beats, sum the payload and check ack packets, emit commands.
// ----------------------------------------------------------------------------
module abs_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  abs_pkg::in_beat_t in_data_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output abs_pkg::cmd_t    cmd_o
);
  import abs_pkg::*;

  logic                     st_valid_q;
  in_beat_t                 st_q;
  logic [BASE_W-1:0]        psum_lo_q, psum_lo_d;
  logic [BASE_W-1:0]        psum_hi_q, psum_hi_d;
  logic                     nz_q, nz_d;
  logic [8*MSG_BYTES-1:0]   flat;
  logic [7:0]               bval;
  logic [BASE_W-1:0]        term;
  logic [BASE_W-1:0]        base;
  logic [31:0]              ack_sum;

  // Weighted sum of the incoming payload, split in two halves
  always_comb begin
    flat      = {in_data_i.data_high, in_data_i.data_mid, in_data_i.data_low};
    psum_lo_d = '0;
    psum_hi_d = '0;
    nz_d      = 1'b1;
    bval      = '0;
    term      = '0;
    for (int unsigned i = 0; i < MSG_BYTES; i++) begin
      bval = flat[8*i +: 8];
      term = {{(BASE_W-8){bval[7]}}, bval} * BASE_W'(msg_weight(i));
      if (i < HALF_BYTES) begin
        psum_lo_d = psum_lo_d + term;
      end else begin
        psum_hi_d = psum_hi_d + term;
      end
      nz_d = nz_d & (|bval);
    end
  end

  assign in_ready_o  = !st_valid_q || cmd_ready_i;
  assign cmd_valid_o = st_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      st_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      st_q      <= in_data_i;
      psum_lo_q <= psum_lo_d;
      psum_hi_q <= psum_hi_d;
      nz_q      <= nz_d;
    end
  end

  // Finish the sum, check an ack and classify
  always_comb begin
    base    = nz_q ? (psum_lo_q + psum_hi_q) : '0;
    ack_sum = {{(32-BASE_W){base[BASE_W-1]}}, base}
            + (st_q.pkt_seq + 32'(SEQ_BIAS)) * 32'(W_FIRST)
            + (st_q.pkt_ack + 32'(ACK_BIAS)) * 32'(W_LAST);

    cmd_o.ent.msg.low  = st_q.data_low;
    cmd_o.ent.msg.mid  = st_q.data_mid;
    cmd_o.ent.msg.high = st_q.data_high;
    cmd_o.ent.base     = base;
    cmd_o.ack_bit      = st_q.pkt_ack[0];
    cmd_o.ack_ok       = (st_q.pkt_check == ack_sum) && (st_q.pkt_ack[31:1] == '0);
    unique case (st_q.mode)
      MODE_MSG:   cmd_o.kind = CMD_MSG;
      MODE_ACK:   cmd_o.kind = CMD_ACK;
      MODE_TIMER: cmd_o.kind = CMD_TIMER;
      default:    cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

// ===== sv/abs_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// abs_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module abs_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  abs_pkg::cmd_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output abs_pkg::cmd_t rd_data_o
);
  import abs_pkg::*;

  localparam int unsigned PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CMD_DEPTH + 1);

  cmd_t          mem_q [CMD_DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] count_q;
  logic          push, pop;

  assign wr_ready_o = (count_q != CW'(CMD_DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PW'(CMD_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PW'(CMD_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== sv/abs_back.sv =====
// ----------------------------------------------------------------------------
// abs_back
// Carry out commands: sequence bit, message queue, resend and result beat.
// ----------------------------------------------------------------------------
module abs_back #(
  parameter int unsigned QUEUE_DEPTH = abs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  abs_pkg::cmd_t     cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output abs_pkg::out_beat_t out_data_o
);
  import abs_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  back_state_e state_q, state_d;
  logic        idle_q, idle_d;
  logic        seq_q, seq_d;
  q_entry_t    last_q, last_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic        out_valid_q, out_valid_d;
  out_beat_t   out_q, out_d;
  logic        out_free;
  logic        ram_we, ram_re;
  q_entry_t    ram_rdata;

  function automatic out_beat_t make_send(input q_entry_t e, input logic seq,
                                          input tmr_e tmr);
    out_beat_t r;
    r.send_valid = 1'b1;
    r.send_seq   = seq;
    r.send_check = {{(32-BASE_W){e.base[BASE_W-1]}}, e.base}
                 + 32'(SEND_BIAS) + 32'(seq) * 32'(W_FIRST);
    r.send_low   = e.msg.low;
    r.send_mid   = e.msg.mid;
    r.send_high  = e.msg.high;
    r.timer_cmd  = tmr;
    r.dropped    = 1'b0;
    return r;
  endfunction

  abs_ram #(
    .WIDTH($bits(q_entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(cmd_i.ent),
    .re_i   (ram_re),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == BK_IDLE) && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idle_q      <= 1'b1;
      seq_q       <= 1'b0;
      last_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idle_q      <= idle_d;
      seq_q       <= seq_d;
      last_q      <= last_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    idle_d      = idle_q;
    seq_d       = seq_q;
    last_d      = last_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && cmd_ready_o) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          case (cmd_i.kind)
            CMD_MSG: begin
              if (idle_q) begin
                out_d  = make_send(cmd_i.ent, seq_q, TMR_START);
                last_d = cmd_i.ent;
                idle_d = 1'b0;
              end else if (count_q == CW'(QUEUE_DEPTH)) begin
                out_d.dropped = 1'b1;
              end else begin
                ram_we  = 1'b1;
                tail_d  = (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            CMD_ACK: begin
              if (cmd_i.ack_ok && (cmd_i.ack_bit == seq_q)) begin
                seq_d = !seq_q;
                if (count_q == '0) begin
                  idle_d          = 1'b1;
                  out_d.timer_cmd = TMR_STOP;
                end else begin
                  // hold the result until the head entry is read out
                  ram_re      = 1'b1;
                  head_d      = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
                  count_d     = count_q - 1'b1;
                  out_valid_d = 1'b0;
                  state_d     = BK_READ;
                end
              end
            end
            CMD_TIMER: begin
              out_d  = make_send(last_q, seq_q, TMR_START);
              idle_d = 1'b0;
            end
            default: begin
              out_d = '0;
            end
          endcase
        end
      end
      BK_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = make_send(ram_rdata, seq_q, TMR_RESTART);
          last_d      = ram_rdata;
          idle_d      = 1'b0;
          state_d     = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_q |-> (count_q == '0))
    else $error("sender idle with queued messages");

  a_read_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> (state_q == BK_READ))
    else $error("queue read without read state");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("queue written and read in one cycle");

  a_read_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_READ) |-> !cmd_ready_o)
    else $error("command taken while head read pending");

endmodule

// ===== sv/alternating_bit_sender.sv =====
// ----------------------------------------------------------------------------
// alternating_bit_sender
// Sender side of an alternating-bit link: queue messages, check acks,
// resend on timer expiry, one result beat per event beat.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake              | Payload             | Direction
//  ---------+------------------------+---------------------+----------
//  in       | in_valid_i / in_ready_o   | in_data_i (in_beat_t)  | event in
//  out      | out_valid_o / out_ready_i | out_data_o (out_beat_t)| result out
//
//  An event beat passes the registered front stage (payload sum, ack
//  checksum compare), waits in a two-entry command queue, then reaches the
//  result register in the back. An accepted ack that serves a queued message
//  also passes a read state in the back, set by the registered read port of
//  the message queue RAM; the back takes no command while that read is pending.
//  Reset is asynchronous and active low; the queue RAM needs no clearing.
//  A stalled output holds the back, the command queue fills, then in_ready_o
//  drops; the front keeps working while a result waits.
//
module alternating_bit_sender #(
  parameter int unsigned QUEUE_DEPTH = abs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  abs_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output abs_pkg::out_beat_t out_data_o
);
  import abs_pkg::*;

  // front -> queue
  logic fr_valid, fr_ready;
  cmd_t fr_cmd;
  // queue -> back
  logic bk_valid, bk_ready;
  cmd_t bk_cmd;

  // Classify events and precompute checksums
  abs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cmd_valid_o(fr_valid),
    .cmd_ready_i(fr_ready),
    .cmd_o      (fr_cmd)
  );

  // Decouple front and back stalls
  abs_cmd_fifo u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fr_valid),
    .wr_ready_o(fr_ready),
    .wr_data_i (fr_cmd),
    .rd_valid_o(bk_valid),
    .rd_ready_i(bk_ready),
    .rd_data_o (bk_cmd)
  );

  // Advance protocol state and drive the result register
  abs_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(bk_valid),
    .cmd_ready_o(bk_ready),
    .cmd_i      (bk_cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== bench/tb_alternating_bit_sender.sv =====
// ----------------------------------------------------------------------------
// tb_alternating_bit_sender
// Self-checking bench for the alternating-bit sender: feeds message, ack,
// timer and spare-mode beats under random idling on both channels, and checks
// every result beat against a cycle-free model of the sender.
// ----------------------------------------------------------------------------
module tb_alternating_bit_sender;
  import abs_pkg::*;

  localparam int unsigned DEPTH       = QUEUE_DEPTH_DEF;
  localparam int unsigned FRAME_BYTES = 20;
  localparam logic [31:0] SEQ_OFFSET  = 32'd10;
  localparam logic [31:0] ACK_OFFSET  = 32'd15;
  localparam logic [31:0] W_HEAD      = 32'd4;    // weight of byte 0
  localparam logic [31:0] W_TAIL      = 32'd42;   // weight of byte 19
  localparam logic [1:0]  MODE_SPARE  = 2'd3;     // unused mode, must be ignored
  localparam int unsigned STALL_LIMIT = 2000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_beat_t out_data_o;

  alternating_bit_sender u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Event beats waiting to be driven, and result beats the model predicts
  in_beat_t    pending_events[$];
  out_beat_t   expected_sends[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned source_idle_pct;
  int unsigned sink_idle_pct;
  bit          event_taken;

  // Model state of the sender
  logic        sh_idle;
  logic        sh_seq;
  msg_t        sh_last;
  msg_t        sh_backlog[DEPTH];
  int unsigned sh_head;
  int unsigned sh_tail;
  int unsigned sh_count;

  // Sequence bit as the stimulus side sees it, to build acks that get through
  logic        gen_seq;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Model of the sender
  // --------------------------------------------------------------------------

  // Weighted checksum, wrapping at 32 bits; payload bytes are signed. Any zero
  // byte (byte 0 included) voids the payload part and leaves only the biases.
  function automatic logic [31:0] frame_sum(msg_t m, logic [31:0] seq_f,
                                            logic [31:0] ack_f);
    logic [159:0] f;
    logic [7:0]   b;
    logic [31:0]  acc;
    logic         any_zero;
    f        = m;
    acc      = '0;
    any_zero = 1'b0;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      b = f[8*i +: 8];
      if (b == 8'h00) any_zero = 1'b1;
      acc = acc + {{24{b[7]}}, b} * 32'((i + 2) * 2);
    end
    if (any_zero) acc = '0;
    return acc + (seq_f + SEQ_OFFSET) * W_HEAD + (ack_f + ACK_OFFSET) * W_TAIL;
  endfunction

  // Put a data packet on the wire with the current bit and remember it
  task automatic transmit(input msg_t m, inout out_beat_t res);
    res.send_valid = 1'b1;
    res.send_seq   = sh_seq;
    res.send_check = frame_sum(m, {31'b0, sh_seq}, 32'd0);
    res.send_low   = m.low;
    res.send_mid   = m.mid;
    res.send_high  = m.high;
    sh_last        = m;
    sh_idle        = 1'b0;
  endtask

  task automatic sender_step(input in_beat_t ev, output out_beat_t res);
    msg_t m;
    res    = '0;
    m.low  = ev.data_low;
    m.mid  = ev.data_mid;
    m.high = ev.data_high;
    case (ev.mode)
      MODE_MSG: begin
        if (sh_idle) begin
          transmit(m, res);
          res.timer_cmd = TMR_START;
        end else if (sh_count >= DEPTH) begin
          res.dropped = 1'b1;
        end else begin
          sh_backlog[sh_tail] = m;
          sh_tail  = (sh_tail + 1) % DEPTH;
          sh_count = sh_count + 1;
        end
      end
      MODE_ACK: begin
        if (ev.pkt_ack == {31'b0, sh_seq} &&
            ev.pkt_check == frame_sum(m, ev.pkt_seq, ev.pkt_ack)) begin
          // toggle first, so a served message carries the new bit
          sh_seq = ~sh_seq;
          if (sh_count == 0) begin
            sh_idle       = 1'b1;
            res.timer_cmd = TMR_STOP;
          end else begin
            m        = sh_backlog[sh_head];
            sh_head  = (sh_head + 1) % DEPTH;
            sh_count = sh_count - 1;
            transmit(m, res);
            res.timer_cmd = TMR_RESTART;
          end
        end
      end
      MODE_TIMER: begin
        transmit(sh_last, res);
        res.timer_cmd = TMR_START;
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic msg_t fill_bytes(logic [7:0] b);
    return msg_t'({FRAME_BYTES{b}});
  endfunction

  // Mostly payloads with no zero byte, so the full weighted sum is exercised;
  // the rest hit the zero-byte rules and the byte extremes.
  function automatic msg_t random_payload();
    logic [159:0] f;
    int unsigned  k;
    k = $urandom_range(99);
    for (int i = 0; i < FRAME_BYTES; i++) f[8*i +: 8] = 8'($urandom_range(255, 1));
    if (k < 15) begin
      f = {$urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (k < 25) begin
      f[8*$urandom_range(FRAME_BYTES - 1) +: 8] = 8'h00;
    end else if (k < 30) begin
      f[7:0] = 8'h00;
    end else if (k < 38) begin
      case ($urandom_range(4))
        0:       f = fill_bytes(8'h00);
        1:       f = fill_bytes(8'hFF);
        2:       f = fill_bytes(8'h80);
        3:       f = fill_bytes(8'h7F);
        default: f = fill_bytes(8'h01);
      endcase
    end
    return msg_t'(f);
  endfunction

  // Queue one event beat; track the bit when an ack will be taken
  task automatic push_event(input logic [1:0] md, input msg_t m,
                            input logic [31:0] s, input logic [31:0] a,
                            input logic [31:0] c);
    in_beat_t ev;
    ev.mode      = md;
    ev.data_low  = m.low;
    ev.data_mid  = m.mid;
    ev.data_high = m.high;
    ev.pkt_seq   = s;
    ev.pkt_ack   = a;
    ev.pkt_check = c;
    if (md == MODE_ACK && a == {31'b0, gen_seq} && c == frame_sum(m, s, a))
      gen_seq = ~gen_seq;
    pending_events.push_back(ev);
  endtask

  task automatic push_msg(input msg_t m);
    push_event(MODE_MSG, m, $urandom, $urandom, $urandom);
  endtask

  task automatic push_timer();
    push_event(MODE_TIMER, random_payload(), $urandom, $urandom, $urandom);
  endtask

  task automatic push_good_ack(input msg_t m, input logic [31:0] s);
    push_event(MODE_ACK, m, s, {31'b0, gen_seq}, frame_sum(m, s, {31'b0, gen_seq}));
  endtask

  // Mixed traffic: messages roughly balanced against good acks so the sender
  // moves between idle, busy with a short queue, and back again.
  task automatic queue_traffic(input int unsigned n);
    int unsigned added;
    int unsigned pick;
    int unsigned len;
    int unsigned kind;
    msg_t        m;
    logic [31:0] s;
    logic [31:0] a;
    logic [31:0] c;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(99);
      m    = random_payload();
      s    = $urandom;
      if (pick < 30) begin
        len = $urandom_range(2, 1);
        repeat (len) push_msg(random_payload());
        added += len;
      end else if (pick < 68) begin
        push_good_ack(m, s);
        added++;
      end else if (pick < 80) begin
        // broken ack: wrong bit, out-of-range ack field, bad or random check
        kind = $urandom_range(3);
        a    = {31'b0, gen_seq};
        if (kind == 0) a = {31'b0, ~gen_seq};
        if (kind == 1) a = $urandom | 32'h2;
        if (kind == 3) a = $urandom;
        c = frame_sum(m, s, a);
        if (kind == 2) c = c ^ (32'h1 << $urandom_range(31));
        if (kind == 3) c = $urandom;
        push_event(MODE_ACK, m, s, a, c);
        added++;
      end else if (pick < 94) begin
        push_timer();
        added++;
      end else begin
        push_event(MODE_SPARE, m, s, $urandom, $urandom);
      end
    end
  endtask

  task automatic report_mismatch(input string text);
    $display("mismatch: %s", text);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                results_seen, name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Driver: take beats at the rising edge, drive the next at the falling edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : accept
    out_beat_t res;
    if (rst_ni && in_valid_i && in_ready_o) begin
      sender_step(in_data_i, res);
      expected_sends.push_back(res);
      event_taken = 1'b1;
    end
  end

  // Hold valid and payload until taken; then drive the next beat or go idle
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || event_taken)) begin
      event_taken = 1'b0;
      if (pending_events.size() != 0 && $urandom_range(99) >= source_idle_pct) begin
        in_data_i  <= pending_events.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result beat with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_sends.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected",
                                  results_seen));
      end else begin
        want = expected_sends.pop_front();
        check_field("send_valid", 64'(out_data_o.send_valid), 64'(want.send_valid));
        check_field("send_seq",   64'(out_data_o.send_seq),   64'(want.send_seq));
        check_field("send_check", 64'(out_data_o.send_check), 64'(want.send_check));
        check_field("send_low",   out_data_o.send_low,        want.send_low);
        check_field("send_mid",   out_data_o.send_mid,        want.send_mid);
        check_field("send_high",  64'(out_data_o.send_high),  64'(want.send_high));
        check_field("timer_cmd",  64'(out_data_o.timer_cmd),  64'(want.timer_cmd));
        check_field("dropped",    64'(out_data_o.dropped),    64'(want.dropped));
      end
      results_seen++;
    end
  end

  // Watchdog: end the run when neither channel moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence of the run
  // --------------------------------------------------------------------------
  initial begin : run
    msg_t        m;
    logic [31:0] s;
    logic [31:0] a;
    in_valid_i      = 1'b0;
    in_data_i       = '0;
    out_ready_i     = 1'b0;
    rst_ni          = 1'b0;
    mismatches      = 0;
    results_seen    = 0;
    event_taken     = 1'b0;
    sh_idle         = 1'b1;
    sh_seq          = 1'b0;
    sh_last         = '0;
    sh_head         = 0;
    sh_tail         = 0;
    sh_count        = 0;
    gen_seq         = 1'b0;
    source_idle_pct = 34;
    sink_idle_pct   = 46;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: timer on the cleared last message, spare mode, acks
    // taken while busy and while idle
    push_timer();
    push_event(MODE_SPARE, fill_bytes(8'hFF), '1, '1, '1);
    push_good_ack(fill_bytes(8'h01), 32'h0);
    push_good_ack(fill_bytes(8'hFF), 32'hFFFF_FFFF);

    // Send one at once, then queue the byte extremes and the zero-byte cases
    push_msg(fill_bytes(8'hFF));
    push_msg(fill_bytes(8'h7F));
    push_msg(fill_bytes(8'h80));
    m = fill_bytes(8'h55);
    m.low[7:0] = 8'h00;
    push_msg(m);
    m = fill_bytes(8'hA3);
    m.high[31:24] = 8'h00;
    push_msg(m);

    // Rejected acks: wrong bit, out-of-range ack fields, one bad check bit
    m = fill_bytes(8'h11);
    s = 32'h1234_5678;
    a = {31'b0, ~gen_seq};
    push_event(MODE_ACK, m, s, a, frame_sum(m, s, a));
    a = 32'h8000_0000;
    push_event(MODE_ACK, m, s, a, frame_sum(m, s, a));
    a = 32'h2;
    push_event(MODE_ACK, m, s, a, frame_sum(m, s, a));
    a = {31'b0, gen_seq};
    push_event(MODE_ACK, m, s, a, frame_sum(m, s, a) ^ 32'h8000_0000);

    // Drain the queue with taken acks, a resend in between, and one to spare
    push_good_ack(fill_bytes(8'h80), 32'h7FFF_FFFF);
    push_good_ack(fill_bytes(8'h7F), 32'h8000_0000);
    push_timer();
    push_good_ack(random_payload(), 32'h0);
    push_good_ack(random_payload(), $urandom);
    push_good_ack(random_payload(), $urandom);
    push_msg(fill_bytes(8'h00));
    push_msg(fill_bytes(8'h01));
    push_event(MODE_SPARE, fill_bytes(8'h00), '0, '0, '0);

    // Overfill the queue so messages drop, then empty it again
    repeat (DEPTH + 6) push_msg(random_payload());
    repeat (DEPTH + 8) push_good_ack(random_payload(), $urandom);
    queue_traffic(150);
    while (pending_events.size() != 0 || in_valid_i || expected_sends.size() != 0)
      @(posedge clk_i);

    // Swap the idling of the two sides
    source_idle_pct = 46;
    sink_idle_pct   = 34;
    queue_traffic(150);
    while (pending_events.size() != 0 || in_valid_i || expected_sends.size() != 0)
      @(posedge clk_i);

    // Full rate on both sides
    source_idle_pct = 0;
    sink_idle_pct   = 0;
    queue_traffic(150);
    while (pending_events.size() != 0 || in_valid_i || expected_sends.size() != 0)
      @(posedge clk_i);

    // Let any stray beat show up before the verdict
    repeat (20) @(posedge clk_i);
    if (expected_sends.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_sends.size()));
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
